// ===== rtl/tsp_pkg.sv =====
// Package for the trapezoid stepper profile unit: codes, state enum and
// arithmetic constants. No dependencies.
package tsp_pkg;

    // command kinds
    localparam logic [2:0] KIND_GOTO   = 3'd0;
    localparam logic [2:0] KIND_HOME   = 3'd1;
    localparam logic [2:0] KIND_CANCEL = 3'd2;
    localparam logic [2:0] KIND_CLEAR  = 3'd3;
    localparam logic [2:0] KIND_STEP   = 3'd4;

    // start codes
    localparam logic [2:0] SC_INVALID = 3'd0;
    localparam logic [2:0] SC_BUSY    = 3'd1;
    localparam logic [2:0] SC_DONE    = 3'd2;
    localparam logic [2:0] SC_STARTED = 3'd3;
    localparam logic [2:0] SC_NONE    = 3'd4;

    typedef enum logic [2:0] {
        M_IDLE      = 3'd0,
        M_HOMING    = 3'd1,
        M_MOVING    = 3'd2,
        M_HOME_OK   = 3'd3,
        M_HOME_FAIL = 3'd4,
        M_GOTO_DONE = 3'd5
    } t_mode;

    // shared serial arithmetic unit operations
    typedef enum logic [1:0] {
        AOP_MUL  = 2'd0,
        AOP_DIV  = 2'd1,
        AOP_SQRT = 2'd2
    } t_aop;

    typedef struct packed {
        logic start;
        t_aop op;
    } t_arith_req;

    localparam int          SWITCH_COUNT = 16;
    localparam logic [63:0] C_TWO_E12    = 64'd2000000000000;
    localparam logic [31:0] C_US_PER_S   = 32'd1000000;
    localparam logic [63:0] C_US_Q16     = 64'd65536000000;
    localparam logic [20:0] PERIOD_MAX   = 21'h1FFFFF;

endpackage

// ===== rtl/tsp_in_if.sv =====
// Input channel of the stepper profile unit: valid/ready plus command fields.
// No dependencies.
interface tsp_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [31:0] target_position;
    logic [31:0] home_step_limit;
    logic [23:0] accel_rate;
    logic [15:0] speed_limit;
    logic [3:0]  switch_select;
    logic        switch_stop_level;
    logic [15:0] switch_word;

    modport source (output valid, kind, target_position, home_step_limit, accel_rate,
                    speed_limit, switch_select, switch_stop_level, switch_word,
                    input ready);
    modport sink   (input valid, kind, target_position, home_step_limit, accel_rate,
                    speed_limit, switch_select, switch_stop_level, switch_word,
                    output ready);
endinterface

// ===== rtl/tsp_out_if.sv =====
// Output channel of the stepper profile unit: valid/ready plus result fields.
// No dependencies.
interface tsp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  start_code;
    logic [2:0]  motion_state;
    logic        step_pulse;
    logic        dir_level;
    logic [31:0] axis_position;
    logic [20:0] next_period_us;
    logic        clear_ok;

    modport source (output valid, start_code, motion_state, step_pulse, dir_level,
                    axis_position, next_period_us, clear_ok, input ready);
    modport sink   (input valid, start_code, motion_state, step_pulse, dir_level,
                    axis_position, next_period_us, clear_ok, output ready);
endinterface

// ===== rtl/tsp_arith.sv =====
// Shared bit-serial arithmetic unit: shift-add multiply, restoring
// divide 64/32, digit-by-digit square root of 96 bits. Uses tsp_pkg.
module tsp_arith (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tsp_pkg::t_arith_req i_req,
    input  logic [95:0]         i_x,
    input  logic [31:0]         i_y,
    output logic                o_done,
    output logic [63:0]         o_res
);
    logic [6:0]    r_cnt;
    tsp_pkg::t_aop r_op;
    logic [95:0]   r_a;
    logic [31:0]   r_b;
    logic [63:0]   r_r;
    logic [63:0]   r_q;
    logic          r_done;

    logic [32:0] n_dt;
    logic        n_dge;
    logic [51:0] n_st;
    logic [51:0] n_trial;
    logic        n_sge;

    // one divide and one root step
    always_comb begin
        n_dt    = {r_r[31:0], r_a[95]};
        n_dge   = n_dt >= {1'b0, r_b};
        n_st    = {r_r[49:0], r_a[95:94]};
        n_trial = {1'b0, r_q[48:0], 2'b01};
        n_sge   = n_st >= n_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_op <= i_req.op;
                r_r  <= '0;
                r_q  <= '0;
                case (i_req.op)
                    tsp_pkg::AOP_MUL: begin
                        r_a   <= {i_y, 64'd0};
                        r_b   <= i_x[31:0];
                        r_cnt <= 7'd32;
                    end
                    tsp_pkg::AOP_DIV: begin
                        r_a   <= {i_x[63:0], 32'd0};
                        r_b   <= i_y;
                        r_cnt <= 7'd64;
                    end
                    default: begin
                        r_a   <= i_x;
                        r_b   <= i_y;
                        r_cnt <= 7'd48;
                    end
                endcase
            end else if (r_cnt != 7'd0) begin
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) r_done <= 1'b1;
                case (r_op)
                    tsp_pkg::AOP_MUL: begin
                        r_r <= {r_r[62:0], 1'b0} + (r_a[95] ? {32'd0, r_b} : 64'd0);
                        r_a <= {r_a[94:0], 1'b0};
                    end
                    tsp_pkg::AOP_DIV: begin
                        r_r <= n_dge ? {32'd0, n_dt[31:0] - r_b} : {32'd0, n_dt[31:0]};
                        r_q <= {r_q[62:0], n_dge};
                        r_a <= {r_a[94:0], 1'b0};
                    end
                    default: begin
                        r_r <= n_sge ? {12'd0, n_st - n_trial} : {12'd0, n_st};
                        r_q <= {r_q[62:0], n_sge};
                        r_a <= {r_a[93:0], 2'b00};
                    end
                endcase
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = (r_op == tsp_pkg::AOP_MUL) ? r_r : r_q;
endmodule

// ===== rtl/trapezoid_stepper_profile_unit.sv =====
// Top level of the trapezoid stepper profile unit: command decode, motion
// state and sequencer. Uses tsp_pkg, tsp_in_if, tsp_out_if and tsp_arith.
//
//  port    | dir | words
//  --------+-----+------------------------------------------------
//  i_in    | in  | command: goto, home, cancel, clear, step event
//  o_out   | out | one status word per command
//
// Cancel, clear, rejects and ignored events go from decode straight to S_OUT.
// A goto/home start runs mul, div, div and sqrt on the serial unit, plus mul and
// sqrt for a triangular profile; a new-period step event runs mul, div and div.
// Reset (synchronous, active low) puts the axis idle at position zero.
// i_in is taken in the idle state even while a result waits in the output
// register; a stalled output holds the sequencer before its next result.
module trapezoid_stepper_profile_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tsp_in_if.sink    i_in,
    tsp_out_if.source o_out
);
    typedef enum logic [3:0] {
        S_IDLE, S_EXEC, S_ACC_MUL, S_ACC_DIV, S_P0_DIV, S_P0_SQRT, S_PK_MUL,
        S_PK_SQRT, S_DV_MUL, S_DV_DIV, S_VEL, S_PER, S_PER_DIV, S_OUT
    } t_state;

    t_state r_state;

    // latched command word
    logic [2:0]  r_kind;
    logic [31:0] r_tgt, r_lim;
    logic [23:0] r_acl;
    logic [15:0] r_spd;
    logic [3:0]  r_sel;
    logic        r_lvl;
    logic [15:0] r_word;

    // axis state
    tsp_pkg::t_mode r_mode;
    logic [31:0] r_pos, r_left, r_vel, r_peak, r_dmark, r_cmark, r_amark;
    logic [20:0] r_per;
    logic [23:0] r_acch;
    logic        r_dirp;
    logic [3:0]  r_hidx;
    logic        r_hlvl;

    // planning scratch
    logic [31:0] r_tot, r_acc;
    logic        r_isgoto, r_big;
    logic [63:0] r_dv;
    logic [2:0]  r_code;
    logic        r_pulse, r_clr;

    // arithmetic unit
    tsp_pkg::t_arith_req r_req;
    logic [95:0] r_ax;
    logic [31:0] r_ay;
    logic        w_done;
    logic [63:0] w_res;

    // output register
    logic        r_oval;
    logic [2:0]  r_o_code, r_o_state;
    logic        r_o_pulse, r_o_dir, r_o_clr;
    logic [31:0] r_o_pos;
    logic [20:0] r_o_per;

    tsp_arith u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_req),
        .i_x     (r_ax),
        .i_y     (r_ay),
        .o_done  (w_done),
        .o_res   (w_res)
    );

    // command decode helpers
    logic [31:0] n_delta, n_gmag, n_hmag, n_left;
    logic        n_stop, n_active, n_badp, n_fin;
    logic [31:0] n_accs, n_decs, n_cons;
    logic [20:0] n_sat;

    always_comb begin
        n_delta  = r_tgt - r_pos;
        n_gmag   = n_delta[31] ? 32'd0 - n_delta : n_delta;
        n_hmag   = r_lim[31] ? 32'd0 - r_lim : r_lim;
        n_left   = r_left - 32'd1;
        n_active = (r_mode == tsp_pkg::M_HOMING) || (r_mode == tsp_pkg::M_MOVING);
        n_fin    = (r_mode == tsp_pkg::M_HOME_OK) || (r_mode == tsp_pkg::M_HOME_FAIL)
                   || (r_mode == tsp_pkg::M_GOTO_DONE);
        n_badp   = (r_acl == 24'd0) || (r_spd == 16'd0);
        n_stop   = (r_mode == tsp_pkg::M_HOMING)
                   && ((32'(r_hidx) < tsp_pkg::SWITCH_COUNT) ? r_word[r_hidx] : 1'b0)
                      == r_hlvl;
        n_sat    = (w_res > 64'(tsp_pkg::PERIOD_MAX)) ? tsp_pkg::PERIOD_MAX : w_res[20:0];
        // phase split of the planned move
        if (r_isgoto) begin
            if (r_big) begin
                n_accs = {1'b0, r_tot[31:1]};
                n_decs = r_tot - {1'b0, r_tot[31:1]};
                n_cons = 32'd0;
            end else begin
                n_accs = r_acc;
                n_decs = r_acc;
                n_cons = r_tot - {r_acc[30:0], 1'b0};
            end
        end else begin
            n_decs = 32'd0;
            n_accs = r_big ? r_tot : r_acc;
            n_cons = r_tot - n_accs;
        end
    end

    assign i_in.ready = (r_state == S_IDLE);

    // sequencer, axis state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_mode    <= tsp_pkg::M_IDLE;
            r_pos     <= '0;
            r_left    <= '0;
            r_vel     <= '0;
            r_per     <= '0;
            r_acch    <= '0;
            r_peak    <= '0;
            r_dmark   <= '0;
            r_cmark   <= '0;
            r_amark   <= '0;
            r_dirp    <= 1'b0;
            r_hidx    <= '0;
            r_hlvl    <= 1'b0;
            r_req     <= '0;
            r_oval    <= 1'b0;
        end else begin
            // start is a one-cycle pulse; no request is issued while it is high
            if (r_req.start) r_req.start <= 1'b0;
            // S_OUT reloads the output register itself
            if (o_out.valid && o_out.ready && r_state != S_OUT) r_oval <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_kind  <= i_in.kind;
                        r_tgt   <= i_in.target_position;
                        r_lim   <= i_in.home_step_limit;
                        r_acl   <= i_in.accel_rate;
                        r_spd   <= i_in.speed_limit;
                        r_sel   <= i_in.switch_select;
                        r_lvl   <= i_in.switch_stop_level;
                        r_word  <= i_in.switch_word;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_pulse <= (r_kind == tsp_pkg::KIND_STEP) && n_active && !n_stop;
                    r_clr   <= (r_kind == tsp_pkg::KIND_CLEAR) && n_fin;
                    case (r_kind)
                        tsp_pkg::KIND_GOTO: begin
                            if (r_mode != tsp_pkg::M_IDLE) begin
                                r_code  <= tsp_pkg::SC_BUSY;
                                r_state <= S_OUT;
                            end else if (n_badp) begin
                                r_code  <= tsp_pkg::SC_INVALID;
                                r_state <= S_OUT;
                            end else if (n_gmag == 32'd0) begin
                                r_code  <= tsp_pkg::SC_DONE;
                                r_state <= S_OUT;
                            end else begin
                                r_code   <= tsp_pkg::SC_STARTED;
                                r_tot    <= n_gmag;
                                r_dirp   <= !n_delta[31];
                                r_isgoto <= 1'b1;
                                r_ax     <= {80'd0, r_spd};
                                r_ay     <= {16'd0, r_spd};
                                r_req    <= '{start: 1'b1, op: tsp_pkg::AOP_MUL};
                                r_state  <= S_ACC_MUL;
                            end
                        end
                        tsp_pkg::KIND_HOME: begin
                            if (r_mode != tsp_pkg::M_IDLE) begin
                                r_code  <= tsp_pkg::SC_BUSY;
                                r_state <= S_OUT;
                            end else if (n_hmag == 32'd0) begin
                                r_code  <= tsp_pkg::SC_DONE;
                                r_state <= S_OUT;
                            end else if (n_badp) begin
                                r_code  <= tsp_pkg::SC_INVALID;
                                r_state <= S_OUT;
                            end else begin
                                r_code   <= tsp_pkg::SC_STARTED;
                                r_tot    <= n_hmag;
                                r_dirp   <= !r_lim[31];
                                r_hidx   <= r_sel;
                                r_hlvl   <= r_lvl;
                                r_isgoto <= 1'b0;
                                r_ax     <= {80'd0, r_spd};
                                r_ay     <= {16'd0, r_spd};
                                r_req    <= '{start: 1'b1, op: tsp_pkg::AOP_MUL};
                                r_state  <= S_ACC_MUL;
                            end
                        end
                        tsp_pkg::KIND_CANCEL: begin
                            r_code  <= tsp_pkg::SC_NONE;
                            r_mode  <= tsp_pkg::M_IDLE;
                            r_left  <= '0;
                            r_per   <= '0;
                            r_state <= S_OUT;
                        end
                        tsp_pkg::KIND_CLEAR: begin
                            r_code  <= tsp_pkg::SC_NONE;
                            if (n_fin) r_mode <= tsp_pkg::M_IDLE;
                            r_state <= S_OUT;
                        end
                        tsp_pkg::KIND_STEP: begin
                            r_code <= tsp_pkg::SC_NONE;
                            if (n_active && n_stop) begin
                                r_pos   <= '0;
                                r_mode  <= tsp_pkg::M_HOME_OK;
                                r_left  <= '0;
                                r_per   <= '0;
                                r_state <= S_OUT;
                            end else if (n_active) begin
                                r_left <= n_left;
                                r_pos  <= r_dirp ? r_pos + 32'd1 : r_pos - 32'd1;
                                if (n_left == 32'd0) begin
                                    r_mode  <= (r_mode == tsp_pkg::M_HOMING)
                                               ? tsp_pkg::M_HOME_FAIL : tsp_pkg::M_GOTO_DONE;
                                    r_per   <= '0;
                                    r_state <= S_OUT;
                                end else begin
                                    r_ax    <= {72'd0, r_acch};
                                    r_ay    <= {11'd0, r_per};
                                    r_req   <= '{start: 1'b1, op: tsp_pkg::AOP_MUL};
                                    r_state <= S_DV_MUL;
                                end
                            end else begin
                                r_state <= S_OUT;
                            end
                        end
                        default: begin
                            r_code  <= tsp_pkg::SC_NONE;
                            r_state <= S_OUT;
                        end
                    endcase
                end
                // accel steps: v*v / 2a
                S_ACC_MUL: begin
                    if (w_done) begin
                        r_ax    <= {64'd0, w_res[31:0]};
                        r_ay    <= {7'd0, r_acl, 1'b0};
                        r_req   <= '{start: 1'b1, op: tsp_pkg::AOP_DIV};
                        r_state <= S_ACC_DIV;
                    end
                end
                S_ACC_DIV: begin
                    if (w_done) begin
                        r_acc   <= w_res[31:0];
                        r_ax    <= {32'd0, tsp_pkg::C_TWO_E12};
                        r_ay    <= {8'd0, r_acl};
                        r_req   <= '{start: 1'b1, op: tsp_pkg::AOP_DIV};
                        r_state <= S_P0_DIV;
                    end
                end
                // start period: sqrt(2e12 / a)
                S_P0_DIV: begin
                    if (w_done) begin
                        r_ax    <= {32'd0, w_res};
                        r_req   <= '{start: 1'b1, op: tsp_pkg::AOP_SQRT};
                        r_state <= S_P0_SQRT;
                    end
                end
                S_P0_SQRT: begin
                    if (w_done) begin
                        r_per  <= n_sat;
                        r_left <= r_tot;
                        r_acch <= r_acl;
                        r_vel  <= '0;
                        r_big  <= r_isgoto ? ({r_acc, 1'b0} > {1'b0, r_tot}) : (r_acc > r_tot);
                        if (r_isgoto ? ({r_acc, 1'b0} > {1'b0, r_tot}) : (r_acc > r_tot)) begin
                            r_ax    <= {72'd0, r_acl};
                            r_ay    <= r_tot;
                            r_req   <= '{start: 1'b1, op: tsp_pkg::AOP_MUL};
                            r_state <= S_PK_MUL;
                        end else begin
                            r_peak  <= {r_spd, 16'd0};
                            r_state <= S_PK_SQRT;
                        end
                    end
                end
                // triangular peak: sqrt(a*steps << 32); also commits the plan
                S_PK_MUL: begin
                    if (w_done) begin
                        r_ax    <= {w_res, 32'd0};
                        r_req   <= '{start: 1'b1, op: tsp_pkg::AOP_SQRT};
                        r_state <= S_PK_SQRT;
                    end
                end
                S_PK_SQRT: begin
                    if (w_done || !r_big) begin
                        if (r_big) r_peak <= w_res[31:0];
                        r_dmark <= n_decs;
                        r_cmark <= n_decs + n_cons;
                        r_amark <= n_decs + n_cons + n_accs;
                        r_mode  <= r_isgoto ? tsp_pkg::M_MOVING : tsp_pkg::M_HOMING;
                        r_state <= S_OUT;
                    end
                end
                // velocity change: a * period << 16 / 1e6
                S_DV_MUL: begin
                    if (w_done) begin
                        r_ax    <= {32'd0, w_res[47:0], 16'd0};
                        r_ay    <= tsp_pkg::C_US_PER_S;
                        r_req   <= '{start: 1'b1, op: tsp_pkg::AOP_DIV};
                        r_state <= S_DV_DIV;
                    end
                end
                S_DV_DIV: begin
                    if (w_done) begin
                        r_dv    <= w_res;
                        r_state <= S_VEL;
                    end
                end
                // velocity update per phase; decel down to zero ends the move
                S_VEL: begin
                    if (r_left <= r_dmark && r_dv >= {32'd0, r_vel}) begin
                        r_mode  <= (r_mode == tsp_pkg::M_HOMING)
                                   ? tsp_pkg::M_HOME_FAIL : tsp_pkg::M_GOTO_DONE;
                        r_left  <= '0;
                        r_per   <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_PER;
                        if (r_left <= r_dmark) begin
                            r_vel <= r_vel - r_dv[31:0];
                        end else if (r_left <= r_cmark) begin
                            r_vel <= r_peak;
                        end else if (r_left <= r_amark) begin
                            r_vel <= (({32'd0, r_vel} + r_dv) > {32'd0, r_peak})
                                     ? r_peak : r_vel + r_dv[31:0];
                        end
                    end
                end
                // next period: 1e6 << 16 / v
                S_PER: begin
                    if (r_vel == 32'd0) begin
                        r_per   <= tsp_pkg::PERIOD_MAX;
                        r_state <= S_OUT;
                    end else begin
                        r_ax    <= {32'd0, tsp_pkg::C_US_Q16};
                        r_ay    <= r_vel;
                        r_req   <= '{start: 1'b1, op: tsp_pkg::AOP_DIV};
                        r_state <= S_PER_DIV;
                    end
                end
                S_PER_DIV: begin
                    if (w_done) begin
                        r_per   <= n_sat;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_oval || o_out.ready) begin
                        r_oval    <= 1'b1;
                        r_o_code  <= r_code;
                        r_o_state <= r_mode;
                        r_o_pulse <= r_pulse;
                        r_o_dir   <= r_dirp;
                        r_o_pos   <= r_pos;
                        r_o_per   <= n_active ? r_per : 21'd0;
                        r_o_clr   <= r_clr;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid          = r_oval;
    assign o_out.start_code     = r_o_code;
    assign o_out.motion_state   = r_o_state;
    assign o_out.step_pulse     = r_o_pulse;
    assign o_out.dir_level      = r_o_dir;
    assign o_out.axis_position  = r_o_pos;
    assign o_out.next_period_us = r_o_per;
    assign o_out.clear_ok       = r_o_clr;
endmodule

// ===== tb/sv/tsp_checker.sv =====
// Checker for the trapezoid stepper profile unit: watches both channels,
// predicts each status word and compares. Depends on tsp_pkg and the channel interfaces.
module tsp_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tsp_in_if           i_in,
    tsp_out_if          i_out,
    output int          o_fail_count,
    output int          o_pending,
    output logic [31:0] o_position
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [2:0]  start_code;
        logic [2:0]  motion_state;
        logic        step_pulse;
        logic        dir_level;
        logic [31:0] axis_position;
        logic [20:0] next_period_us;
        logic        clear_ok;
    } t_status;

    t_status status_q[$];
    int      fail_count;

    // axis copy
    tsp_pkg::t_mode mode;
    logic [31:0] pos, left, vel, peak, dmark, cmark, amark;
    logic [20:0] period;
    logic [23:0] accel;
    logic        dir_pos;
    logic [3:0]  sw_idx;
    logic        sw_lvl;

    assign o_fail_count = fail_count;
    assign o_pending    = status_q.size();
    assign o_position   = pos;

    function automatic logic [63:0] int_root(input logic [63:0] x);
        logic [63:0] r, b;
        r = 64'd0;
        b = 64'h4000_0000_0000_0000;
        while (b > x) b = b >> 2;
        while (b != 64'd0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [20:0] clamp_period(input logic [63:0] p);
        return (p > {43'd0, tsp_pkg::PERIOD_MAX}) ? tsp_pkg::PERIOD_MAX : p[20:0];
    endfunction

    function automatic logic [20:0] period_of(input logic [31:0] v);
        if (v == 32'd0) return tsp_pkg::PERIOD_MAX;
        return clamp_period(tsp_pkg::C_US_Q16 / {32'd0, v});
    endfunction

    task automatic halt_axis(input tsp_pkg::t_mode m);
        mode   = m;
        left   = 32'd0;
        period = 21'd0;
    endtask

    task automatic plan_move(input logic [31:0] total, input logic neg,
                             input logic [23:0] a, input logic [15:0] v, input logic is_goto);
        logic [63:0] acc, prod;
        logic [31:0] up, down, cruise, pk;
        acc  = ({48'd0, v} * {48'd0, v}) / (64'd2 * {40'd0, a});
        prod = ({40'd0, a} * {32'd0, total}) << 32;
        pk   = {v, 16'd0};
        dir_pos = !neg;
        left    = total;
        accel   = a;
        vel     = 32'd0;
        period  = clamp_period(int_root(tsp_pkg::C_TWO_E12 / {40'd0, a}));
        if (is_goto) begin
            if (64'd2 * acc > {32'd0, total}) begin
                pk     = 32'(int_root(prod));
                up     = total / 32'd2;
                down   = total - up;
                cruise = 32'd0;
            end else begin
                up     = acc[31:0];
                down   = up;
                cruise = total - 32'd2 * up;
            end
        end else begin
            if (acc > {32'd0, total}) begin
                up = total;
                pk = 32'(int_root(prod));
            end else begin
                up = acc[31:0];
            end
            cruise = total - up;
            down   = 32'd0;
        end
        peak  = pk;
        dmark = down;
        cmark = down + cruise;
        amark = down + cruise + up;
        mode  = is_goto ? tsp_pkg::M_MOVING : tsp_pkg::M_HOMING;
    endtask

    // one command word in, one predicted status word out
    task automatic predict_word();
        t_status        s;
        logic [31:0]    delta, mag, lim;
        logic [63:0]    dv, nv;
        logic           neg, hit, sw_bit, ended;
        tsp_pkg::t_mode miss;
        s = '0;
        s.start_code = tsp_pkg::SC_NONE;
        case (i_in.kind)
            tsp_pkg::KIND_GOTO: begin
                delta = i_in.target_position - pos;
                neg   = delta[31];
                mag   = neg ? 32'd0 - delta : delta;
                if (mode != tsp_pkg::M_IDLE) s.start_code = tsp_pkg::SC_BUSY;
                else if (i_in.accel_rate == 24'd0 || i_in.speed_limit == 16'd0)
                    s.start_code = tsp_pkg::SC_INVALID;
                else if (mag == 32'd0) s.start_code = tsp_pkg::SC_DONE;
                else begin
                    plan_move(mag, neg, i_in.accel_rate, i_in.speed_limit, 1'b1);
                    s.start_code = tsp_pkg::SC_STARTED;
                end
            end
            tsp_pkg::KIND_HOME: begin
                lim = i_in.home_step_limit;
                neg = lim[31];
                mag = neg ? 32'd0 - lim : lim;
                if (mode != tsp_pkg::M_IDLE) s.start_code = tsp_pkg::SC_BUSY;
                else if (mag == 32'd0) s.start_code = tsp_pkg::SC_DONE;
                else if (i_in.accel_rate == 24'd0 || i_in.speed_limit == 16'd0)
                    s.start_code = tsp_pkg::SC_INVALID;
                else begin
                    sw_idx = i_in.switch_select;
                    sw_lvl = i_in.switch_stop_level;
                    plan_move(mag, neg, i_in.accel_rate, i_in.speed_limit, 1'b0);
                    s.start_code = tsp_pkg::SC_STARTED;
                end
            end
            tsp_pkg::KIND_CANCEL: halt_axis(tsp_pkg::M_IDLE);
            tsp_pkg::KIND_CLEAR: begin
                if (mode == tsp_pkg::M_HOME_OK || mode == tsp_pkg::M_HOME_FAIL
                    || mode == tsp_pkg::M_GOTO_DONE) begin
                    mode       = tsp_pkg::M_IDLE;
                    s.clear_ok = 1'b1;
                end
            end
            tsp_pkg::KIND_STEP: begin
                if (mode == tsp_pkg::M_HOMING || mode == tsp_pkg::M_MOVING) begin
                    miss = (mode == tsp_pkg::M_HOMING) ? tsp_pkg::M_HOME_FAIL
                                                       : tsp_pkg::M_GOTO_DONE;
                    hit  = 1'b0;
                    if (mode == tsp_pkg::M_HOMING) begin
                        sw_bit = (32'(sw_idx) < tsp_pkg::SWITCH_COUNT)
                                 ? i_in.switch_word[sw_idx] : 1'b0;
                        hit    = (sw_bit == sw_lvl);
                    end
                    if (hit) begin
                        pos = 32'd0;
                        halt_axis(tsp_pkg::M_HOME_OK);
                    end else begin
                        left         = left - 32'd1;
                        pos          = dir_pos ? pos + 32'd1 : pos - 32'd1;
                        s.step_pulse = 1'b1;
                        if (left == 32'd0) begin
                            halt_axis(miss);
                        end else begin
                            dv    = (({40'd0, accel} * {43'd0, period}) << 16) / 64'd1000000;
                            ended = 1'b0;
                            if (left <= dmark) begin
                                if (dv >= {32'd0, vel}) begin
                                    halt_axis(miss);
                                    ended = 1'b1;
                                end else begin
                                    vel = vel - dv[31:0];
                                end
                            end else if (left <= cmark) begin
                                vel = peak;
                            end else if (left <= amark) begin
                                nv  = {32'd0, vel} + dv;
                                vel = (nv > {32'd0, peak}) ? peak : nv[31:0];
                            end
                            if (!ended) period = period_of(vel);
                        end
                    end
                end
            end
            default: ;
        endcase
        s.motion_state   = mode;
        s.dir_level      = dir_pos;
        s.axis_position  = pos;
        s.next_period_us = (mode == tsp_pkg::M_HOMING || mode == tsp_pkg::M_MOVING)
                           ? period : 21'd0;
        status_q.push_back(s);
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    task automatic compare_word();
        t_status w;
        if (status_q.size() == 0) begin
            report("unexpected word", i_out.axis_position, 32'd0);
            return;
        end
        w = status_q.pop_front();
        if (i_out.start_code != w.start_code)
            report("start_code", 32'(i_out.start_code), 32'(w.start_code));
        if (i_out.motion_state != w.motion_state)
            report("motion_state", 32'(i_out.motion_state), 32'(w.motion_state));
        if (i_out.step_pulse != w.step_pulse)
            report("step_pulse", 32'(i_out.step_pulse), 32'(w.step_pulse));
        if (i_out.dir_level != w.dir_level)
            report("dir_level", 32'(i_out.dir_level), 32'(w.dir_level));
        if (i_out.axis_position != w.axis_position)
            report("axis_position", i_out.axis_position, w.axis_position);
        if (i_out.next_period_us != w.next_period_us)
            report("next_period_us", 32'(i_out.next_period_us), 32'(w.next_period_us));
        if (i_out.clear_ok != w.clear_ok)
            report("clear_ok", 32'(i_out.clear_ok), 32'(w.clear_ok));
    endtask

    initial fail_count = 0;

    // sample both channels at the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            status_q.delete();
            mode = tsp_pkg::M_IDLE;
            pos = 32'd0; left = 32'd0; vel = 32'd0; peak = 32'd0;
            dmark = 32'd0; cmark = 32'd0; amark = 32'd0;
            period = 21'd0; accel = 24'd0; dir_pos = 1'b0; sw_idx = 4'd0; sw_lvl = 1'b0;
        end else begin
            if (i_out.valid && i_out.ready) compare_word();
            if (i_in.valid && i_in.ready) predict_word();
        end
    end

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench top for the trapezoid stepper profile unit: clock, reset, command
// stimulus and verdict. Depends on tsp_pkg, the channel interfaces and tsp_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1500000;
    localparam int WORD_TARGET = 650;

    logic        i_clk;
    logic        i_rst_n;
    int          fail_count, pending, cycles, words_sent;
    logic [31:0] axis_pos;
    logic        calm;   // no idling on either side

    tsp_in_if  in_ch();
    tsp_out_if out_ch();

    trapezoid_stepper_profile_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    tsp_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_position   (axis_pos)
    );

    always begin
        i_clk = 1'b0; #5;
        i_clk = 1'b1; #5;
    end

    // run limit
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    function automatic int idle_gap();
        return calm ? 0 : int'($urandom_range(0, 4));
    endfunction

    // receiver: random stall before each word
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_ch.ready = 1'b0;
            repeat (idle_gap()) @(negedge i_clk);
            out_ch.ready = 1'b1;
            do @(posedge i_clk); while (!(out_ch.valid && out_ch.ready));
        end
    end

    task automatic send_word(input logic [2:0] kind, input logic [31:0] tgt,
                             input logic [31:0] lim, input logic [23:0] a,
                             input logic [15:0] v, input logic [3:0] sel,
                             input logic lvl, input logic [15:0] sw);
        repeat (idle_gap()) @(negedge i_clk);
        in_ch.kind              = kind;
        in_ch.target_position   = tgt;
        in_ch.home_step_limit   = lim;
        in_ch.accel_rate        = a;
        in_ch.speed_limit       = v;
        in_ch.switch_select     = sel;
        in_ch.switch_stop_level = lvl;
        in_ch.switch_word       = sw;
        in_ch.valid             = 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        words_sent++;
    endtask

    // short command with random filler in the unused fields
    task automatic send_simple(input logic [2:0] kind, input logic [15:0] sw);
        send_word(kind, $urandom, $urandom, 24'($urandom), 16'($urandom), 4'($urandom),
                  1'($urandom), sw);
    endtask

    task automatic drain();
        wait (pending == 0);
        @(negedge i_clk);
    endtask

    // accel spread over its whole range, biased to useful values
    function automatic logic [23:0] rand_accel();
        case ($urandom_range(0, 3))
            0: return 24'($urandom);
            1: return 24'($urandom_range(1, 255));
            default: return 24'($urandom_range(500, 200000));
        endcase
    endfunction

    function automatic logic [15:0] rand_speed();
        return $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(50, 5000));
    endfunction

    task automatic random_goto();
        int          span;
        logic [31:0] tgt;
        drain();
        span = $urandom_range(0, 9) == 0 ? int'($urandom_range(0, 120))
                                         : int'($urandom_range(0, 25));
        tgt  = $urandom_range(0, 1) ? axis_pos + 32'(span) : axis_pos - 32'(span);
        if ($urandom_range(0, 19) == 0) tgt = $urandom;
        send_word(tsp_pkg::KIND_GOTO, tgt, $urandom,
                  $urandom_range(0, 30) == 0 ? 24'd0 : rand_accel(),
                  $urandom_range(0, 30) == 0 ? 16'd0 : rand_speed(), 4'($urandom),
                  1'($urandom), 16'($urandom));
        repeat (span + int'($urandom_range(0, 2)))
            send_simple(tsp_pkg::KIND_STEP, 16'($urandom));
        if ($urandom_range(0, 5) == 0) send_simple(tsp_pkg::KIND_GOTO, 16'($urandom));
        send_simple($urandom_range(0, 3) == 0 ? tsp_pkg::KIND_CANCEL : tsp_pkg::KIND_CLEAR,
                    16'($urandom));
    endtask

    task automatic random_home();
        int          budget;
        logic [3:0]  sel;
        logic        lvl;
        logic [15:0] sw;
        budget = $urandom_range(0, 9) == 0 ? int'($urandom_range(0, 100))
                                           : int'($urandom_range(0, 25));
        sel    = 4'($urandom);
        lvl    = 1'($urandom);
        send_word(tsp_pkg::KIND_HOME, $urandom,
                  $urandom_range(0, 1) ? 32'(budget) : 32'(-budget),
                  $urandom_range(0, 30) == 0 ? 24'd0 : rand_accel(),
                  $urandom_range(0, 30) == 0 ? 16'd0 : rand_speed(), sel, lvl,
                  16'($urandom));
        repeat (budget + int'($urandom_range(0, 2))) begin
            sw = 16'($urandom);
            if ($urandom_range(0, 9) != 0) sw[sel] = !lvl;
            send_simple(tsp_pkg::KIND_STEP, sw);
        end
        send_simple($urandom_range(0, 3) == 0 ? tsp_pkg::KIND_CANCEL : tsp_pkg::KIND_CLEAR,
                    16'($urandom));
    endtask

    initial begin
        calm                    = 1'b0;
        words_sent              = 0;
        in_ch.valid             = 1'b0;
        in_ch.kind              = tsp_pkg::KIND_CANCEL;
        in_ch.target_position   = '0;
        in_ch.home_step_limit   = '0;
        in_ch.accel_rate        = '0;
        in_ch.speed_limit       = '0;
        in_ch.switch_select     = '0;
        in_ch.switch_stop_level = 1'b0;
        in_ch.switch_word       = '0;
        i_rst_n                 = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: ignored kinds, rejects and zero-distance starts
        send_simple(tsp_pkg::KIND_STEP, 16'hFFFF);
        send_simple(tsp_pkg::KIND_CLEAR, 16'h0000);
        send_simple(3'd5, 16'h0);
        send_simple(3'd7, 16'h0);
        send_word(tsp_pkg::KIND_GOTO, 32'd10, 32'd0, 24'd0, 16'd100, 4'd0, 1'b0, 16'd0);
        send_word(tsp_pkg::KIND_GOTO, 32'd10, 32'd0, 24'd1000, 16'd0, 4'd0, 1'b0, 16'd0);
        send_word(tsp_pkg::KIND_GOTO, 32'd0, 32'd0, 24'd1000, 16'd100, 4'd0, 1'b0, 16'd0);
        send_word(tsp_pkg::KIND_HOME, 32'd0, 32'd0, 24'd0, 16'd0, 4'd0, 1'b0, 16'd0);
        send_word(tsp_pkg::KIND_HOME, 32'd0, 32'd5, 24'd0, 16'd100, 4'd0, 1'b0, 16'd0);
        // largest distance with extreme rates, then busy reject and cancel
        send_word(tsp_pkg::KIND_GOTO, 32'h8000_0000, 32'd0, 24'hFFFFFF, 16'hFFFF, 4'd0, 1'b0,
                  16'd0);
        send_simple(tsp_pkg::KIND_STEP, 16'd0);
        send_simple(tsp_pkg::KIND_STEP, 16'd0);
        send_word(tsp_pkg::KIND_HOME, 32'd0, 32'd3, 24'd1, 16'd1, 4'd0, 1'b0, 16'd0);
        send_simple(tsp_pkg::KIND_CANCEL, 16'd0);
        // home with full negative budget, switch hit on second event
        send_word(tsp_pkg::KIND_HOME, 32'd0, 32'h8000_0000, 24'd1, 16'd1, 4'd15, 1'b1, 16'd0);
        send_simple(tsp_pkg::KIND_STEP, 16'h7FFF);
        send_simple(tsp_pkg::KIND_STEP, 16'h8000);
        send_simple(tsp_pkg::KIND_HOME, 16'd0);
        send_simple(tsp_pkg::KIND_CLEAR, 16'd0);
        // long goto cancelled, then short triangular goto run to completion
        send_word(tsp_pkg::KIND_GOTO, 32'h7FFF_FFFF, 32'd0, 24'd1, 16'd1, 4'd0, 1'b0, 16'd0);
        send_simple(tsp_pkg::KIND_CANCEL, 16'd0);
        send_word(tsp_pkg::KIND_GOTO, 32'hFFFF_FFFD, 32'd0, 24'd5000, 16'd400, 4'd0, 1'b0,
                  16'd0);
        drain();  // sender waits out every pending word
        repeat (4) send_simple(tsp_pkg::KIND_STEP, 16'd0);
        send_simple(tsp_pkg::KIND_CLEAR, 16'd0);

        // random sequences, alternating stretches with and without idling
        while (words_sent < WORD_TARGET) begin
            calm = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 9))
                0: send_simple(3'($urandom_range(0, 7)), 16'($urandom));
                1, 2, 3, 4, 5: random_goto();
                default: random_home();
            endcase
        end

        calm = 1'b0;
        drain();
        repeat (400) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
